// ===== src/fcl_pkg.sv =====
// fcl_pkg: shared types and constants of the fully connected layer.
// No dependencies.
`default_nettype none
package fcl_pkg;
  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_BIAS   = 2'd1;
  localparam logic [1:0] CMD_FWD    = 2'd2;
  localparam logic [1:0] CMD_BWD    = 2'd3;
  localparam int ACC_W = 40;
  localparam logic CFG_IN_SIZE  = 1'b0;
  localparam logic CFG_OUT_SIZE = 1'b1;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [15:0] q88_t;
endpackage
`default_nettype wire

// ===== src/fully_connected_layer_top.sv =====
// fully_connected_layer_top: linear layer, shared MAC over a chain of
// accumulator cells. Depends on fcl_pkg, fcl_ram, fcl_cell.
//
// A weight or bias beat is written while idle, so stall stays low. A vector
// element reads n weights (n = rows forward, columns backward), none when its
// index is out of range; stall stays high until its pass and any emission end.
// One weight RAM read per cycle feeds the single multiplier, whose product
// lands in the cell picked by the delayed read index; the RAM read and the
// product register drain after the last read. On last, each result is a bias
// read, then the output register loads while the cells shift toward cell 0
// (held while an output stall holds the previous result); then the cells are
// cleared. Weights and biases must be written before use.
`default_nettype none
module fully_connected_layer_top #(
  parameter int MAX_IN  = 16,
  parameter int MAX_OUT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  output logic             stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [3:0]  row,
  input  wire logic [3:0]  col,
  input  wire logic signed [15:0] value,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] result,
  output logic [3:0]       index,
  output logic             direction,
  output logic             saturated,
  output logic             final_res,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data
);
  import fcl_pkg::*;
  localparam int NC = (MAX_IN > MAX_OUT) ? MAX_IN : MAX_OUT;
  localparam int WD = MAX_IN * MAX_OUT;
  localparam int WA = (WD > 1) ? $clog2(WD) : 1;
  localparam int BA = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int CB = $clog2(NC + 1);
  localparam int IN_CAP = (MAX_IN < 16) ? MAX_IN : 16;
  localparam int OUT_CAP = (MAX_OUT < 16) ? MAX_OUT : 16;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state;
  logic [4:0] in_size, out_size;
  logic [4:0] ni, no;
  logic [CB-1:0] cnt, n_emit;
  logic fwd, lst, mvalid;
  logic signed [15:0] xval;
  logic [3:0] erow, ecol;
  logic [CB-1:0] mcell;
  logic signed [31:0] prod;

  always_comb begin
    ni = (in_size > 5'(IN_CAP)) ? 5'(IN_CAP) : in_size;
    no = (out_size > 5'(OUT_CAP)) ? 5'(OUT_CAP) : out_size;
  end

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      in_size <= 5'd16;
      out_size <= 5'd16;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_IN_SIZE) in_size <= cfg_data;
      else out_size <= cfg_data;
    end
  end

  logic acc_in;
  assign stall = (state != S_IDLE);
  assign acc_in = valid && !stall;

  logic w_we;
  logic [WA-1:0] w_wa, w_ra;
  logic [15:0] w_rd;
  logic [BA-1:0] b_ra;
  logic [15:0] b_rd;
  logic b_we;
  assign w_we = acc_in && (cmd == CMD_WEIGHT) && ({1'b0, row} < no) && ({1'b0, col} < ni);
  assign w_wa = WA'(row) * WA'(MAX_IN) + WA'(col);
  assign b_we = acc_in && (cmd == CMD_BIAS) && ({1'b0, row} < no);

  always_comb begin
    if (fwd) w_ra = WA'(cnt) * WA'(MAX_IN) + WA'(ecol);
    else w_ra = WA'(erow) * WA'(MAX_IN) + WA'(cnt);
  end
  fcl_ram #(.WIDTH(16), .DEPTH(WD)) u_wram (
    .clk(clk), .we(w_we), .waddr(w_wa), .wdata(value), .raddr(w_ra), .rdata(w_rd));
  fcl_ram #(.WIDTH(16), .DEPTH(MAX_OUT)) u_bram (
    .clk(clk), .we(b_we), .waddr(BA'(row)), .wdata(value), .raddr(b_ra),
    .rdata(b_rd));

  // cells
  acc_t acc [NC];
  logic shift, clr, eshift;
  logic [NC-1:0] add_v;
  logic rd_go;
  logic [CB-1:0] rcell, ecnt;
  always_comb begin
    for (int k = 0; k < NC; k++) add_v[k] = mvalid && (mcell == CB'(k));
  end
  for (genvar k = 0; k < NC; k++) begin : g_cell
    acc_t nbr;
    if (k == NC - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = acc[k+1];
    end
    fcl_cell u_cell (.clk(clk), .add(add_v[k]), .prod(prod), .shift(shift),
      .clear(clr), .nbr(nbr), .acc(acc[k]));
  end

  // MAC pipeline: read address cnt, data next cycle, product registered
  logic rd_v;
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      mvalid <= 1'b0;
    end else begin
      rd_v <= rd_go;
      mvalid <= rd_v;
    end
    rcell <= cnt;
    mcell <= rcell;
    if (rd_v) prod <= 32'(signed'(w_rd)) * 32'(xval);
  end

  logic in_rng;
  logic [CB-1:0] nmac;
  always_ff @(posedge clk) begin
    if (acc_in) begin
      fwd <= (cmd == CMD_FWD);
      lst <= last;
      xval <= value;
      erow <= row;
      ecol <= col;
    end
  end
  assign nmac = fwd ? CB'(no) : CB'(ni);
  assign in_rng = fwd ? ({1'b0, ecol} < ni) : ({1'b0, erow} < no);
  assign rd_go = (state == S_MAC) && in_rng && (cnt < nmac);

  // emission: cell 0 drained each step, bias read alongside
  logic signed [ACC_W:0] sum;
  logic signed [ACC_W-8:0] q;
  logic busy_o;
  assign b_ra = BA'(ecnt);
  assign busy_o = out_valid && out_stall;
  assign shift = eshift;

  logic [1:0] ph;
  always_comb begin
    sum = {acc[0][ACC_W-1], acc[0]};
    if (fwd) sum = sum + ((ACC_W+1)'(signed'(b_rd)) <<< 8);
    q = sum[ACC_W:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      ecnt <= '0;
      out_valid <= 1'b0;
      ph <= '0;
    end else begin
      if (out_valid && !out_stall && !eshift) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc_in && (cmd == CMD_FWD || cmd == CMD_BWD)) begin
            state <= S_MAC;
            cnt <= '0;
          end
        end
        S_MAC: begin
          if (rd_go) begin
            cnt <= cnt + 1'b1;
          end else if (!rd_v && !mvalid) begin
            if (lst) begin
              state <= S_EMIT;
              n_emit <= fwd ? CB'(no) : CB'(ni);
              ecnt <= '0;
              ph <= '0;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (ecnt >= n_emit) begin
            if (!out_valid || !out_stall) state <= S_IDLE;
          end else if (ph == 2'd0) begin
            ph <= 2'd1;
          end else if (!busy_o) begin
            ph <= 2'd0;
            out_valid <= 1'b1;
            index <= 4'(ecnt);
            direction <= !fwd;
            final_res <= (ecnt + 1'b1 == n_emit);
            if (q > (ACC_W-7)'(32767)) begin
              result <= 16'sh7fff;
              saturated <= 1'b1;
            end else if (q < -(ACC_W-7)'(32768)) begin
              result <= 16'sh8000;
              saturated <= 1'b1;
            end else begin
              result <= q[15:0];
              saturated <= 1'b0;
            end
            ecnt <= ecnt + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
  assign eshift = (state == S_EMIT) && (ph == 2'd1) && (ecnt < n_emit) && !busy_o;
  assign clr = rst || ((state == S_EMIT) && (ecnt >= n_emit));

  assert property (@(posedge clk) disable iff (rst) (state != S_IDLE) |-> stall)
    else $error("input taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(result))
    else $error("stalled result lost");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !rd_go)
    else $error("MAC running while idle");
endmodule
`default_nettype wire

// ===== src/fcl_ram.sv =====
// fcl_ram: generic single-port-write, single-read RAM, registered read.
// No dependencies.
`default_nettype none
module fcl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/fcl_cell.sv =====
// fcl_cell: one accumulator of the row; adds the product it is given when
// its add input is set, and takes its neighbour's contents along the chain on drain.
// Depends on fcl_pkg.
`default_nettype none
module fcl_cell (
  input  wire logic        clk,
  input  wire logic        add,
  input  wire logic signed [31:0] prod,
  input  wire logic        shift,
  input  wire logic        clear,
  input  wire fcl_pkg::acc_t nbr,
  output fcl_pkg::acc_t    acc
);
  import fcl_pkg::*;
  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (shift) begin
      acc <= nbr;
    end else if (add) begin
      acc <= acc + acc_t'(prod);
    end
  end
endmodule
`default_nettype wire

// ===== bench/tb_fully_connected_layer_top.sv =====
// Testbench for fully_connected_layer_top: random and directed layer traffic with a
// cycle-free predictor of the Q8.8 forward/backward products and a scoreboard.
// Depends on fcl_pkg and the RTL of fully_connected_layer_top.
`timescale 1ns / 1ps
module tb_fully_connected_layer_top;
  import fcl_pkg::*;

  typedef struct {
    logic [1:0] cmd;
    logic [3:0] row;
    logic [3:0] col;
    logic [15:0] value;
    logic last;
  } beat_t;

  typedef struct {
    logic [15:0] result;
    logic [3:0] index;
    logic direction;
    logic saturated;
    logic final_res;
  } elem_t;

  localparam int DRAIN_CYCLES = 80;
  localparam int HANG_LIMIT = 4000;

  logic clk, rst;
  logic valid, stall, last, out_valid, out_stall;
  logic [1:0] cmd;
  logic [3:0] row, col, index;
  logic signed [15:0] value, result;
  logic direction, saturated, final_res;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [4:0] cfg_data;

  fully_connected_layer_top dut (
    .clk(clk), .rst(rst), .valid(valid), .stall(stall), .cmd(cmd), .row(row),
    .col(col), .value(value), .last(last), .out_valid(out_valid),
    .out_stall(out_stall), .result(result), .index(index), .direction(direction),
    .saturated(saturated), .final_res(final_res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  beat_t feed[$];
  elem_t layer_out[$];
  int errs = 0;
  int idle_cycles = 0;
  logic in_taken;

  // predictor state
  q88_t wt[16][16];
  q88_t bs[16];
  acc_t acc[16];
  logic [4:0] in_reg, out_reg;

  function automatic int cap16(logic [4:0] r);
    return (r > 16) ? 16 : int'(r);
  endfunction

  function automatic void layer_step(beat_t b);
    int ni, no, n;
    logic signed [31:0] p;
    acc_t p40;
    logic signed [47:0] s;
    logic signed [47:0] q;
    elem_t e;
    ni = cap16(in_reg);
    no = cap16(out_reg);
    case (b.cmd)
      CMD_WEIGHT: if (b.row < no && b.col < ni) wt[b.row][b.col] = b.value;
      CMD_BIAS: if (b.row < no) bs[b.row] = b.value;
      default: begin
        if (b.cmd == CMD_FWD) begin
          if (b.col < ni)
            for (int k = 0; k < no; k++) begin
              p = wt[k][b.col] * $signed(b.value);
              p40 = p;
              acc[k] = acc[k] + p40;
            end
        end else if (b.row < no) begin
          for (int k = 0; k < ni; k++) begin
            p = wt[b.row][k] * $signed(b.value);
            p40 = p;
            acc[k] = acc[k] + p40;
          end
        end
        if (b.last) begin
          n = (b.cmd == CMD_FWD) ? no : ni;
          for (int k = 0; k < n; k++) begin
            s = acc[k];
            if (b.cmd == CMD_FWD) s = s + 48'(bs[k]) * 256;
            q = s >>> 8;
            e.saturated = 1'b0;
            if (q > 32767) begin
              q = 32767;
              e.saturated = 1'b1;
            end
            if (q < -32768) begin
              q = -32768;
              e.saturated = 1'b1;
            end
            e.result = q[15:0];
            e.index = k[3:0];
            e.direction = (b.cmd == CMD_BWD);
            e.final_res = (k + 1 == n);
            layer_out.push_back(e);
          end
          for (int k = 0; k < 16; k++) acc[k] = '0;
        end
      end
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    beat_t b;
    if (rst) begin
      valid <= 1'b0;
    end else if (valid && !in_taken) begin
    end else if (gap_left > 0) begin
      valid <= 1'b0;
      gap_left--;
    end else if (feed.size() != 0) begin
      b = feed.pop_front();
      cmd <= b.cmd;
      row <= b.row;
      col <= b.col;
      value <= b.value;
      last <= b.last;
      valid <= 1'b1;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end else begin
      valid <= 1'b0;
    end
  end

  // receiver: stall mode changes every so often
  int stall_mode = 0, mode_left = 0;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(10, 60);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    elem_t e;
    in_taken <= valid && !stall;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (valid && !stall) layer_step('{cmd, row, col, value, last});
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IN_SIZE) in_reg = cfg_data;
        else out_reg = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (layer_out.size() == 0) begin
          $error("unexpected result beat: result=%0d index=%0d", result, index);
          errs++;
        end else begin
          e = layer_out.pop_front();
          if (result !== e.result) begin
            $error("result: expected %0d got %0d", $signed(e.result), result);
            errs++;
          end
          if (index !== e.index) begin
            $error("index: expected %0d got %0d", e.index, index);
            errs++;
          end
          if (direction !== e.direction) begin
            $error("direction: expected %0d got %0d", e.direction, direction);
            errs++;
          end
          if (saturated !== e.saturated) begin
            $error("saturated: expected %0d got %0d", e.saturated, saturated);
            errs++;
          end
          if (final_res !== e.final_res) begin
            $error("final_res: expected %0d got %0d", e.final_res, final_res);
            errs++;
          end
        end
      end
      if ((valid && !stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [15:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4: return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void add(logic [1:0] c, int r, int k, logic [15:0] v, logic l);
    beat_t b;
    b.cmd = c;
    b.row = r[3:0];
    b.col = k[3:0];
    b.value = v;
    b.last = l;
    feed.push_back(b);
  endfunction

  task automatic wait_drain();
    while (feed.size() != 0 || valid || layer_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [4:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // a short vector of random content, sometimes mixed or carrying stray indices
  task automatic random_vector(int ni, int no, inout int cnt);
    bit fwd;
    int n;
    logic [1:0] c;
    fwd = 1'($urandom_range(0, 1));
    n = fwd ? ni : no;
    if (n == 0) n = 1;
    if (n > 4) n = $urandom_range(1, 4);
    for (int j = 0; j < n; j++) begin
      c = fwd ? CMD_FWD : CMD_BWD;
      if ($urandom_range(0, 9) == 0) c = fwd ? CMD_BWD : CMD_FWD;
      if ($urandom_range(0, 9) == 0) add(c, $urandom_range(0, 15), $urandom_range(0, 15),
                                         rand_val(), j == n - 1);
      else add(c, j, j, rand_val(), j == n - 1);
      cnt++;
    end
  endtask

  initial begin
    int cnt;
    int ni, no;
    logic [4:0] sizes[6][2] = '{'{5'd16, 5'd2}, '{5'd1, 5'd1}, '{5'd0, 5'd3},
                                '{5'd31, 5'd2}, '{5'd1, 5'd16}, '{5'd16, 5'd0}};
    rst = 1'b1;
    valid = 1'b0;
    cmd = CMD_WEIGHT;
    row = '0;
    col = '0;
    value = '0;
    last = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_IN_SIZE;
    cfg_data = '0;
    in_taken = 1'b0;
    in_reg = 5'd16;
    out_reg = 5'd16;
    for (int k = 0; k < 16; k++) acc[k] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // rows 0-1, column 0 and every bias: all that the size pairs below can read
    for (int r = 0; r < 16; r++) begin
      for (int k = 0; k < 16; k++)
        if (r < 2 || k == 0) add(CMD_WEIGHT, r, k, rand_val(), 1'($urandom_range(0, 1)));
      add(CMD_BIAS, r, 0, rand_val(), 1'($urandom_range(0, 1)));
    end
    wait_drain();

    foreach (sizes[p]) begin
      write_cfg(CFG_IN_SIZE, sizes[p][0]);
      write_cfg(CFG_OUT_SIZE, sizes[p][1]);
      ni = cap16(sizes[p][0]);
      no = cap16(sizes[p][1]);
      if (p == 0) begin
        // extremes, write with last, stray index with last, mixed directions
        add(CMD_WEIGHT, 0, 0, 16'h8000, 1'b1);
        add(CMD_WEIGHT, 15, 15, 16'h7fff, 1'b0);
        add(CMD_BIAS, 0, 0, 16'h7fff, 1'b1);
        add(CMD_BIAS, 15, 0, 16'h8000, 1'b0);
        add(CMD_FWD, 0, 0, 16'h8000, 1'b0);
        add(CMD_FWD, 0, 15, 16'h7fff, 1'b1);
        add(CMD_BWD, 0, 0, 16'h8000, 1'b0);
        add(CMD_BWD, 15, 0, 16'h7fff, 1'b1);
        add(CMD_FWD, 0, 3, 16'h0100, 1'b0);
        add(CMD_BWD, 2, 0, 16'hff00, 1'b1);
        add(CMD_FWD, 0, 9, 16'hffff, 1'b1);
        add(CMD_BWD, 0, 0, 16'h0001, 1'b1);
      end
      if (p == 1) begin
        // sizes of one: stray indices are dropped, last still emits
        add(CMD_WEIGHT, 1, 0, 16'h1234, 1'b0);
        add(CMD_FWD, 0, 1, 16'h7fff, 1'b1);
        add(CMD_BWD, 1, 0, 16'h7fff, 1'b1);
      end
      cnt = 0;
      while (cnt < 5) begin
        case ($urandom_range(0, 5))
          0: begin
            add(2'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 15),
                rand_val(), 1'($urandom_range(0, 1)));
            cnt++;
          end
          1: begin
            add(CMD_WEIGHT, $urandom_range(0, 15), $urandom_range(0, 15), rand_val(),
                1'($urandom_range(0, 1)));
            cnt++;
          end
          default: random_vector(ni, no, cnt);
        endcase
      end
      wait_drain();
    end

    if (errs == 0 && layer_out.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (layer_out.size() != 0) $error("%0d expected results never came", layer_out.size());
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
src/fcl_pkg.sv
src/fcl_ram.sv
src/fcl_cell.sv
src/fully_connected_layer_top.sv
bench/tb_fully_connected_layer_top.sv
